// ----- design/dwq_pkg.sv -----
`timescale 1ns / 1ps

package dwq_pkg;

  // Default sizing
  localparam int QUEUE_DEPTH_DEF   = 32;
  localparam int TASK_ID_WIDTH_DEF = 8;

  // Field widths fixed by the interface
  localparam int FUNC_W = 3;
  localparam int KIND_W = 3;
  localparam int TID_W  = 8;
  localparam int TIME_W = 32;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_REL   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ABS   = 3'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ACK     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TIME    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WAKE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INVALID = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TID_W-1:0]  task_id;
    logic [TIME_W-1:0] amount;
  } in_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TID_W-1:0]  task_id_res;
    logic [TIME_W-1:0] time_value;
    logic              last;
  } out_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic ins_read;
    logic ins_shift;
    logic ins_place;
    logic rel_read;
    logic rel_pop;
    logic emit_more;
    logic emit_last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_insert;
    logic k_zero;
    logic shift_needed;
    logic count_zero;
    logic due;
  } dp_stat_t;

endpackage

// ----- design/dwq_ctrl.sv -----
`timescale 1ns / 1ps

module dwq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dwq_pkg::dp_stat_t stat,
  output dwq_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_INS_RD  = 3'd2;
  localparam logic [2:0] S_INS_CMP = 3'd3;
  localparam logic [2:0] S_REL_RD  = 3'd4;
  localparam logic [2:0] S_REL_CMP = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.is_insert ? S_INS_RD : S_REL_RD;
      end
      S_INS_RD: begin
        if (stat.k_zero) begin
          cmd.ins_place = 1'b1;
          state_nxt     = S_REL_RD;
        end else begin
          cmd.ins_read = 1'b1;
          state_nxt    = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.shift_needed) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = S_INS_RD;
        end else begin
          cmd.ins_place = 1'b1;
          state_nxt     = S_REL_RD;
        end
      end
      S_REL_RD: begin
        if (stat.count_zero) begin
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.rel_read = 1'b1;
          state_nxt    = S_REL_CMP;
        end
      end
      S_REL_CMP: begin
        if (stat.due) begin
          cmd.emit_more = 1'b1;
          cmd.rel_pop   = 1'b1;
          state_nxt     = S_REL_RD;
        end else begin
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/dwq_datapath.sv -----
`timescale 1ns / 1ps

module dwq_datapath #(
  parameter int QUEUE_DEPTH   = dwq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_WIDTH = dwq_pkg::TASK_ID_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dwq_pkg::in_req_t  in_req,
  input  dwq_pkg::dp_cmd_t  cmd,
  output dwq_pkg::dp_stat_t stat,
  output logic              out_strobe,
  output dwq_pkg::out_res_t out_res
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int KW = (TASK_ID_WIDTH < dwq_pkg::TID_W) ? TASK_ID_WIDTH : dwq_pkg::TID_W;
  localparam int TW = dwq_pkg::TIME_W;

  // Latched request
  logic [dwq_pkg::FUNC_W-1:0] func_r;
  logic [KW-1:0]              tid_r;
  logic [TW-1:0]              amount_r;
  logic [TW-1:0]              dl_r;

  // Block state
  logic [TW-1:0] time_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] k_r;

  // Result held back until it is known whether more follow
  logic                       pend_valid_r;
  logic [dwq_pkg::KIND_W-1:0] pend_kind_r;
  logic [KW-1:0]              pend_tid_r;
  logic [TW-1:0]              pend_time_r;

  // Queue store, circular from head_r
  logic [TW-1:0] mem_dl  [QUEUE_DEPTH];
  logic [KW-1:0] mem_tid [QUEUE_DEPTH];
  logic [TW-1:0] rd_dl_r;
  logic [KW-1:0] rd_tid_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  logic          out_strobe_r;
  dwq_pkg::out_res_t out_res_r;

  // Offset from head, modulo depth; sum stays below twice the depth
  function automatic logic [AW-1:0] wrap_idx(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign wr_addr = wrap_idx(head_r, k_r);
  assign rd_addr = cmd.ins_read ? wrap_idx(head_r, k_r - CW'(1)) : head_r;

  // Status to controller
  always_comb begin
    stat.is_insert    = ((func_r == dwq_pkg::FUNC_REL) || (func_r == dwq_pkg::FUNC_ABS))
                        && (count_r != CW'(QUEUE_DEPTH));
    stat.k_zero       = (k_r == '0);
    stat.shift_needed = (rd_dl_r > dl_r);
    stat.count_zero   = (count_r == '0);
    stat.due          = (rd_dl_r <= time_r);
  end

  // Request latch; deadline is fixed at accept time
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_req.func;
      tid_r    <= in_req.task_id[KW-1:0];
      amount_r <= in_req.amount;
      dl_r     <= (in_req.func == dwq_pkg::FUNC_REL) ? time_r + in_req.amount
                                                     : in_req.amount;
    end
  end

  // Queue memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.ins_place) begin
      mem_dl[wr_addr]  <= dl_r;
      mem_tid[wr_addr] <= tid_r;
    end else if (cmd.ins_shift) begin
      mem_dl[wr_addr]  <= rd_dl_r;
      mem_tid[wr_addr] <= rd_tid_r;
    end
    if (cmd.ins_read || cmd.rel_read) begin
      rd_dl_r  <= mem_dl[rd_addr];
      rd_tid_r <= mem_tid[rd_addr];
    end
  end

  // Time, occupancy and insert cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r  <= '0;
      head_r  <= '0;
      count_r <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.exec) begin
        k_r <= count_r;
        if (func_r == dwq_pkg::FUNC_TICK) begin
          time_r <= time_r + amount_r;
        end
      end
      if (cmd.ins_shift) begin
        k_r <= k_r - CW'(1);
      end
      if (cmd.ins_place) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.rel_pop) begin
        count_r <= count_r - CW'(1);
        head_r  <= (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
      end
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      if (cmd.load || cmd.emit_last) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.exec && !stat.is_insert) begin
        pend_valid_r <= 1'b1;
      end
      if (cmd.rel_pop) begin
        pend_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pend_tid_r <= tid_r;
      case (func_r)
        dwq_pkg::FUNC_TICK: begin
          pend_kind_r <= dwq_pkg::KIND_ACK;
          pend_time_r <= '0;
        end
        dwq_pkg::FUNC_QUERY: begin
          pend_kind_r <= dwq_pkg::KIND_TIME;
          pend_time_r <= time_r;
        end
        dwq_pkg::FUNC_REL, dwq_pkg::FUNC_ABS: begin
          pend_kind_r <= dwq_pkg::KIND_FULL;
          pend_time_r <= '0;
        end
        default: begin
          pend_kind_r <= dwq_pkg::KIND_INVALID;
          pend_time_r <= '0;
        end
      endcase
    end
    if (cmd.rel_pop) begin
      pend_kind_r <= dwq_pkg::KIND_WAKE;
      pend_tid_r  <= rd_tid_r;
      pend_time_r <= '0;
    end
  end

  // Output register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (cmd.emit_more || cmd.emit_last) && pend_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_more || cmd.emit_last) begin
      out_res_r.kind        <= pend_kind_r;
      out_res_r.task_id_res <= dwq_pkg::TID_W'(pend_tid_r);
      out_res_r.time_value  <= pend_time_r;
      out_res_r.last        <= cmd.emit_last;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_place |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the queue");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rel_pop |=> count_r == $past(count_r) - CW'(1))
    else $error("release did not shrink the queue");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_place |-> count_r != CW'(QUEUE_DEPTH))
    else $error("insert into a full queue");

endmodule

// ----- design/delayed_wakeup_queue.sv -----
`timescale 1ns / 1ps

// Delayed wakeup queue: tick clock with a sorted queue of sleeping tasks.
// Input: a request (in_req: func, task_id, amount) is taken at a rising edge
// with start high and busy low. busy stays high until every result of that
// request has been issued.
// Output: each result sits on out_res for one cycle, marked by out_strobe;
// the receiver cannot stall, so results are never held back. out_res.last
// flags the final result of a request; a delay that is queued and not yet
// due gives no result at all.
// Sequence: an accepted request passes the execute state, then the release
// scan, which reads the queue head and pops it while it is due; the scan ends
// once the queue is empty or its head is not yet due. A delay that is queued
// first walks the queue from its tail before the scan; each shift step reads
// then writes one queue entry, one place up, until the new entry is placed.
// out_strobe comes from an output register.
// Reset (synchronous, rst_n low) clears time, queue occupancy and the
// controller; queue contents are left as they are, only occupied entries are
// ever read, so no clearing pass is needed.
module delayed_wakeup_queue #(
  parameter int QUEUE_DEPTH   = dwq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_WIDTH = dwq_pkg::TASK_ID_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dwq_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output dwq_pkg::out_res_t out_res
);

  dwq_pkg::dp_cmd_t  cmd;
  dwq_pkg::dp_stat_t stat;

  dwq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  dwq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .TASK_ID_WIDTH (TASK_ID_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule
